// ===== design/square_root_root_finder_macros.svh =====
// Assertion macros for the square root finder checker.
`ifndef SQUARE_ROOT_ROOT_FINDER_MACROS_SVH
`define SQUARE_ROOT_ROOT_FINDER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SRF_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SRF_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/srf_pkg.sv =====
// Types, constants and fixed-point helpers shared by the square root finder.
`timescale 1ns / 1ps

package srf_pkg;

  localparam int W         = 48;
  localparam int FRAC      = 32;
  localparam int PW        = 96;
  localparam int XW        = 98;
  localparam int DW        = 49;
  localparam int AW        = 47;
  localparam int TW        = 33;
  localparam int IW        = 14;
  localparam int MUL_STEPS = 48;
  localparam int DIV_STEPS = 96;
  localparam int CW        = 7;

  localparam logic signed [W-1:0]  SMAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [W-1:0]  SMIN   = 48'sh8000_0000_0000;
  localparam logic signed [XW-1:0] BIGMAX = 98'sd140737488355327;
  localparam logic signed [XW-1:0] BIGMIN = -98'sd140737488355328;
  localparam logic [IW-1:0]        MAXIT_RST = 14'd10000;
  localparam logic [TW-1:0]        TOL_RST   = 33'd1;

  localparam logic CFG_TOL   = 1'b0;
  localparam logic CFG_MAXIT = 1'b1;

  typedef enum logic [1:0] {
    ST_CONV  = 2'd0,
    ST_LIMIT = 2'd1,
    ST_DIVZ  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NEWTON = 2'd0,
    OP_SECANT = 2'd1,
    OP_HERON  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic go;
    logic div;
  } mdu_req_t;

  function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] v);
    sx = $signed({{(XW-W){v[W-1]}}, v});
  endfunction

  function automatic logic signed [W-1:0] sat98(input logic signed [XW-1:0] v);
    if (v > BIGMAX) begin
      sat98 = SMAX;
    end else if (v < BIGMIN) begin
      sat98 = SMIN;
    end else begin
      sat98 = v[W-1:0];
    end
  endfunction

  function automatic logic signed [XW-1:0] smag(input logic neg, input logic [PW-1:0] mag);
    logic signed [XW-1:0] m;
    m = $signed({2'b00, mag});
    smag = neg ? -m : m;
  endfunction

  function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic [PW-1:0] mag);
    sat_mag = sat98(smag(neg, mag));
  endfunction

  function automatic logic [W-1:0] abs48(input logic signed [W-1:0] v);
    abs48 = v[W-1] ? W'(-v) : v;
  endfunction

  function automatic logic signed [W-1:0] resid(input logic [PW-1:0] prod,
                                                input logic [AW-1:0] a);
    resid = sat98($signed({34'd0, prod[PW-1:FRAC]}) - $signed({51'd0, a}));
  endfunction

  function automatic logic below(input logic [DW-1:0] mag, input logic [TW-1:0] tol);
    below = mag < {16'd0, tol};
  endfunction

endpackage

// ===== design/square_root_root_finder.sv =====
// Top level of the square root finder: sequencer, operand registers and ports.
`timescale 1ns / 1ps

// Square root finder in signed Q15.32. An item is taken when start is high and
// busy is low; busy then stays high until the single result word appears on
// root_o, steps_o and status_o for one cycle with done_o, which the receiver
// must take then as it cannot stall. All multiplies and divides run through one shared
// unit on a 50-bit adder. Configuration writes are always ready.

module square_root_root_finder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation_i,
  input  logic [srf_pkg::AW-1:0]         radicand_i,
  input  logic signed [srf_pkg::W-1:0]   initial_guess_i,
  input  logic signed [srf_pkg::W-1:0]   second_guess_i,
  output logic                           done_o,
  output logic signed [srf_pkg::W-1:0]   root_o,
  output logic [srf_pkg::IW-1:0]         steps_o,
  output logic [1:0]                     status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [srf_pkg::TW-1:0]         cfg_data_i
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_START = 15'h0002,
    N_CHECK = 15'h0004,
    N_SQ    = 15'h0008,
    N_DIV   = 15'h0010,
    H_CHECK = 15'h0020,
    H_DIV   = 15'h0040,
    H_UPD   = 15'h0080,
    C_FP    = 15'h0100,
    C_FQ    = 15'h0200,
    C_CHECK = 15'h0400,
    C_M1    = 15'h0800,
    C_M2    = 15'h1000,
    C_DIV   = 15'h2000,
    C_RES   = 15'h4000
  } state_e;

  state_e                          state_q, state_d;
  srf_pkg::op_e                    op_q, op_d;
  logic [srf_pkg::AW-1:0]          a_q, a_d;
  logic signed [srf_pkg::W-1:0]    x_q, x_d;
  logic signed [srf_pkg::W-1:0]    y_q, y_d;
  logic signed [srf_pkg::W-1:0]    fp_q, fp_d;
  logic signed [srf_pkg::W-1:0]    fq_q, fq_d;
  logic signed [srf_pkg::W-1:0]    t_q, t_d;
  logic signed [srf_pkg::XW-1:0]   p1_q, p1_d;
  logic signed [srf_pkg::XW-1:0]   den_q, den_d;
  logic                            sgn_q, sgn_d;
  logic [srf_pkg::IW-1:0]          n_q, n_d;
  logic [srf_pkg::TW-1:0]          tol_q;
  logic [srf_pkg::IW-1:0]          maxit_q;

  logic                            done_q;
  logic signed [srf_pkg::W-1:0]    root_q;
  logic [srf_pkg::IW-1:0]          steps_q;
  srf_pkg::status_e                status_q;

  logic                            fin;
  logic signed [srf_pkg::W-1:0]    fin_root;
  logic [srf_pkg::IW-1:0]          fin_steps;
  srf_pkg::status_e                fin_status;

  srf_pkg::mdu_req_t               req;
  logic [srf_pkg::PW-1:0]          opa;
  logic [srf_pkg::DW-1:0]          opb;
  logic                            mdu_done;
  logic [srf_pkg::PW-1:0]          mdu_res;

  logic [srf_pkg::W-1:0]           mx;
  logic [srf_pkg::W-1:0]           dmag;
  logic signed [srf_pkg::W-1:0]    f;
  logic signed [srf_pkg::W-1:0]    nx;
  logic signed [srf_pkg::XW-1:0]   s98;
  logic signed [srf_pkg::XW-1:0]   w98;
  logic [srf_pkg::XW-1:0]          mag98;

  srf_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign mx   = srf_pkg::abs48(x_q);
  assign dmag = x_q[srf_pkg::W-1]
              ? ((mx > 48'h4000_0000_0000) ? 48'h8000_0000_0000 : {mx[46:0], 1'b0})
              : (mx[46] ? 48'h7FFF_FFFF_FFFF : {mx[46:0], 1'b0});

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    a_d        = a_q;
    x_d        = x_q;
    y_d        = y_q;
    fp_d       = fp_q;
    fq_d       = fq_q;
    t_d        = t_q;
    p1_d       = p1_q;
    den_d      = den_q;
    sgn_d      = sgn_q;
    n_d        = n_q;
    req        = '0;
    opa        = '0;
    opb        = '0;
    fin        = 1'b0;
    fin_root   = x_q;
    fin_steps  = n_q;
    fin_status = srf_pkg::ST_CONV;
    f          = srf_pkg::resid(mdu_res, a_q);
    nx         = '0;
    s98        = '0;
    w98        = '0;
    mag98      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = srf_pkg::op_e'(operation_i);
          a_d     = radicand_i;
          x_d     = initial_guess_i;
          y_d     = second_guess_i;
          n_d     = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        unique case (op_q)
          srf_pkg::OP_NEWTON: state_d = N_CHECK;
          srf_pkg::OP_HERON:  state_d = H_CHECK;
          srf_pkg::OP_SECANT: begin
            req.go  = 1'b1;
            opa     = {48'd0, mx};
            opb     = {1'b0, mx};
            state_d = C_FP;
          end
          srf_pkg::OP_NONE: begin
            fin        = 1'b1;
            fin_steps  = '0;
            fin_status = srf_pkg::ST_LIMIT;
          end
        endcase
      end
      N_CHECK: begin
        if (n_q == maxit_q) begin
          fin        = 1'b1;
          fin_status = srf_pkg::ST_LIMIT;
        end else begin
          req.go  = 1'b1;
          opa     = {48'd0, mx};
          opb     = {1'b0, mx};
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        if (mdu_done) begin
          if (srf_pkg::below({1'b0, srf_pkg::abs48(f)}, tol_q)) begin
            fin = 1'b1;
          end else if (x_q == '0) begin
            fin        = 1'b1;
            fin_status = srf_pkg::ST_DIVZ;
          end else begin
            sgn_d   = f[srf_pkg::W-1] ^ x_q[srf_pkg::W-1];
            req.go  = 1'b1;
            req.div = 1'b1;
            opa     = {16'd0, srf_pkg::abs48(f), 32'd0};
            opb     = {1'b0, dmag};
            state_d = N_DIV;
          end
        end
      end
      N_DIV: begin
        if (mdu_done) begin
          nx      = srf_pkg::sat_mag(sgn_q, mdu_res);
          x_d     = srf_pkg::sat98(srf_pkg::sx(x_q) - srf_pkg::sx(nx));
          n_d     = n_q + 1'b1;
          state_d = N_CHECK;
        end
      end
      H_CHECK: begin
        if (n_q == maxit_q) begin
          fin        = 1'b1;
          fin_status = srf_pkg::ST_LIMIT;
        end else if (x_q == '0) begin
          fin        = 1'b1;
          fin_status = srf_pkg::ST_DIVZ;
        end else begin
          req.go  = 1'b1;
          req.div = 1'b1;
          opa     = {17'd0, a_q, 32'd0};
          opb     = {1'b0, mx};
          state_d = H_DIV;
        end
      end
      H_DIV: begin
        if (mdu_done) begin
          t_d     = srf_pkg::sat_mag(x_q[srf_pkg::W-1], mdu_res);
          state_d = H_UPD;
        end
      end
      H_UPD: begin
        s98   = srf_pkg::sx(t_q) + srf_pkg::sx(x_q);
        w98   = s98 + $signed({{(srf_pkg::XW-1){1'b0}}, s98[srf_pkg::XW-1]});
        nx    = srf_pkg::sat98(w98 >>> 1);
        s98   = srf_pkg::sx(x_q) - srf_pkg::sx(nx);
        mag98 = s98[srf_pkg::XW-1] ? srf_pkg::XW'(-s98) : s98;
        x_d   = nx;
        if (srf_pkg::below(mag98[srf_pkg::DW-1:0], tol_q)) begin
          fin      = 1'b1;
          fin_root = nx;
        end else begin
          n_d     = n_q + 1'b1;
          state_d = H_CHECK;
        end
      end
      C_FP: begin
        if (mdu_done) begin
          fp_d    = f;
          req.go  = 1'b1;
          opa     = {48'd0, srf_pkg::abs48(y_q)};
          opb     = {1'b0, srf_pkg::abs48(y_q)};
          state_d = C_FQ;
        end
      end
      C_FQ: begin
        if (mdu_done) begin
          fq_d    = f;
          state_d = C_CHECK;
        end
      end
      C_CHECK: begin
        s98   = srf_pkg::sx(fq_q) - srf_pkg::sx(fp_q);
        den_d = s98;
        if (n_q == maxit_q) begin
          fin        = 1'b1;
          fin_root   = y_q;
          fin_status = srf_pkg::ST_LIMIT;
        end else if (s98 == '0) begin
          fin        = 1'b1;
          fin_root   = y_q;
          fin_status = srf_pkg::ST_DIVZ;
        end else begin
          req.go  = 1'b1;
          opa     = {48'd0, mx};
          opb     = {1'b0, srf_pkg::abs48(fq_q)};
          state_d = C_M1;
        end
      end
      C_M1: begin
        if (mdu_done) begin
          p1_d    = srf_pkg::smag(x_q[srf_pkg::W-1] ^ fq_q[srf_pkg::W-1], mdu_res);
          req.go  = 1'b1;
          opa     = {48'd0, srf_pkg::abs48(y_q)};
          opb     = {1'b0, srf_pkg::abs48(fp_q)};
          state_d = C_M2;
        end
      end
      C_M2: begin
        if (mdu_done) begin
          s98     = p1_q - srf_pkg::smag(y_q[srf_pkg::W-1] ^ fp_q[srf_pkg::W-1], mdu_res);
          mag98   = s98[srf_pkg::XW-1] ? srf_pkg::XW'(-s98) : s98;
          w98     = den_q[srf_pkg::XW-1] ? -den_q : den_q;
          sgn_d   = s98[srf_pkg::XW-1] ^ den_q[srf_pkg::XW-1];
          req.go  = 1'b1;
          req.div = 1'b1;
          opa     = mag98[srf_pkg::PW-1:0];
          opb     = w98[srf_pkg::DW-1:0];
          state_d = C_DIV;
        end
      end
      C_DIV: begin
        if (mdu_done) begin
          nx      = srf_pkg::sat_mag(sgn_q, mdu_res);
          x_d     = y_q;
          y_d     = nx;
          fp_d    = fq_q;
          req.go  = 1'b1;
          opa     = {48'd0, srf_pkg::abs48(nx)};
          opb     = {1'b0, srf_pkg::abs48(nx)};
          state_d = C_RES;
        end
      end
      C_RES: begin
        if (mdu_done) begin
          fq_d = f;
          if (srf_pkg::below({1'b0, srf_pkg::abs48(f)}, tol_q)) begin
            fin       = 1'b1;
            fin_root  = y_q;
            fin_steps = n_q + 1'b1;
          end else begin
            n_d     = n_q + 1'b1;
            state_d = C_CHECK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) begin
      state_d = S_IDLE;
      if (fin_status == srf_pkg::ST_LIMIT && op_q != srf_pkg::OP_NONE) begin
        fin_steps = maxit_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      tol_q   <= srf_pkg::TOL_RST;
      maxit_q <= srf_pkg::MAXIT_RST;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          srf_pkg::CFG_TOL:   tol_q   <= cfg_data_i;
          srf_pkg::CFG_MAXIT: maxit_q <= cfg_data_i[srf_pkg::IW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    x_q   <= x_d;
    y_q   <= y_d;
    fp_q  <= fp_d;
    fq_q  <= fq_d;
    t_q   <= t_d;
    p1_q  <= p1_d;
    den_q <= den_d;
    sgn_q <= sgn_d;
    n_q   <= n_d;
    if (fin) begin
      root_q   <= fin_root;
      steps_q  <= fin_steps;
      status_q <= fin_status;
    end
  end

  assign done_o   = done_q;
  assign root_o   = root_q;
  assign steps_o  = steps_q;
  assign status_o = status_q;

endmodule

// ===== design/srf_mdu.sv =====
// Shared shift-add multiplier and restoring divider on one adder.
`timescale 1ns / 1ps

module srf_mdu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  srf_pkg::mdu_req_t          req_i,
  input  logic [srf_pkg::PW-1:0]     opa_i,
  input  logic [srf_pkg::DW-1:0]     opb_i,
  output logic                       done_o,
  output logic [srf_pkg::PW-1:0]     res_o
);

  logic                     busy_q, busy_d;
  logic                     div_q, div_d;
  logic                     done_q, done_d;
  logic [srf_pkg::CW-1:0]   cnt_q, cnt_d;
  logic [srf_pkg::DW-1:0]   rem_q, rem_d;
  logic [srf_pkg::PW-1:0]   sh_q, sh_d;
  logic [srf_pkg::DW-1:0]   b_q, b_d;

  logic [srf_pkg::DW:0]     shifted;
  logic [srf_pkg::DW:0]     base;
  logic [srf_pkg::DW:0]     opnd;
  logic [srf_pkg::DW+1:0]   total;
  logic [srf_pkg::DW:0]     sum;
  logic                     ge;
  logic                     last;

  assign shifted = {rem_q, sh_q[srf_pkg::PW-1]};
  assign base    = div_q ? shifted : {1'b0, rem_q};
  assign opnd    = div_q ? ~{1'b0, b_q} : (sh_q[0] ? {1'b0, b_q} : '0);
  assign total   = {1'b0, base} + {1'b0, opnd} + {{(srf_pkg::DW+1){1'b0}}, div_q};
  assign sum     = total[srf_pkg::DW:0];
  assign ge      = total[srf_pkg::DW+1];
  assign last    = div_q ? (cnt_q == srf_pkg::CW'(srf_pkg::DIV_STEPS - 1))
                         : (cnt_q == srf_pkg::CW'(srf_pkg::MUL_STEPS - 1));

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    b_d    = b_q;
    done_d = 1'b0;
    if (req_i.go) begin
      busy_d = 1'b1;
      div_d  = req_i.div;
      cnt_d  = '0;
      rem_d  = '0;
      sh_d   = opa_i;
      b_d    = opb_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (div_q) begin
        rem_d = ge ? sum[srf_pkg::DW-1:0] : shifted[srf_pkg::DW-1:0];
        sh_d  = {sh_q[srf_pkg::PW-2:0], ge};
      end else begin
        rem_d = sum[srf_pkg::DW:1];
        sh_d  = {sum[0], sh_q[srf_pkg::PW-1:1]};
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = div_q ? sh_q
                        : {rem_q[srf_pkg::W-1:0], sh_q[srf_pkg::PW-1:srf_pkg::W]};

endmodule

// ===== design/srf_checker.sv =====
// Port-level checker for the square root finder, bound to the top level.
`timescale 1ns / 1ps
`include "square_root_root_finder_macros.svh"

module srf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o
);

  `SRF_AST_IMP(a_done_idle, done_o, !busy, "result word shown while still busy")
  `SRF_AST_NXT(a_take_busy, start && !busy, busy, "accepted word did not raise busy")
  `SRF_AST_NXT(a_done_once, done_o, !done_o, "result strobe repeated")
  `SRF_AST_IMP(a_status_ok, done_o, status_o <= srf_pkg::ST_DIVZ, "undefined status code")

endmodule

bind square_root_root_finder srf_checker u_srf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .status_o (status_o)
);
